FILE: rtl/core/tat_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tat_pkg
// Shared types and constants of the autotile transition unit: item kinds,
// register indexes, neighbor offsets and default sizes.
// ============================================================================
package tat_pkg;

    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_MAX_ROWS   = 256;
    localparam int DEF_CLASS_BITS = 8;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    typedef enum logic [1:0] {
        KIND_WR_CLASS   = 2'd0,
        KIND_LOAD_TABLE = 2'd1,
        KIND_COMPUTE    = 2'd2,
        KIND_UNUSED     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_MAP_WIDTH    = 3'd0,
        REG_MAP_HEIGHT   = 3'd1,
        REG_MATCH_MODE   = 3'd2,
        REG_SOURCE_CLASS = 3'd3,
        REG_TARGET_CLASS = 3'd4,
        REG_CLEAR_TILE   = 3'd5
    } t_reg;

    localparam logic MODE_PAIR = 1'b0;

    typedef enum logic [1:0] {
        D_NEG  = 2'd0,
        D_ZERO = 2'd1,
        D_POS  = 2'd2
    } t_delta;

    // neighbor order: up, left, right, down, up-left, up-right, down-left, down-right
    function automatic t_delta nb_dx(input logic [2:0] step);
        t_delta d;
        unique case (step)
            3'd0, 3'd3:       d = D_ZERO;
            3'd1, 3'd4, 3'd6: d = D_NEG;
            default:          d = D_POS;
        endcase
        return d;
    endfunction

    function automatic t_delta nb_dy(input logic [2:0] step);
        t_delta d;
        unique case (step)
            3'd0, 3'd4, 3'd5: d = D_NEG;
            3'd1, 3'd2:       d = D_ZERO;
            default:          d = D_POS;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/core/tat_if.sv
`timescale 1ns / 1ps
// ============================================================================
// tat_in_if / tat_out_if
// Valid/ready channels carrying items into and results out of the unit.
// ============================================================================
interface tat_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] cell_class;
    logic [7:0] table_index;
    logic [7:0] table_tile;
    logic       table_valid;

    modport source (output valid, kind, col, row, cell_class, table_index, table_tile,
                    table_valid, input ready);
    modport sink   (input valid, kind, col, row, cell_class, table_index, table_tile,
                    table_valid, output ready);
endinterface

interface tat_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] neighbor_mask;
    logic [7:0] result_tile;
    logic       tile_changed;

    modport source (output valid, neighbor_mask, result_tile, tile_changed, input ready);
    modport sink   (input valid, neighbor_mask, result_tile, tile_changed, output ready);
endinterface

FILE: rtl/core/tile_autotile_transition_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tile_autotile_transition_unit
// Eight-neighbor bitmask autotiler over a class map, a tile map and a
// 256-entry mapping table.
// ============================================================================
// A class write or table load passes through its write state before the next
// item is taken. A compute reads the center and its eight neighbors one per
// cycle through the single read port of the class memory, then reads the
// mapping table and writes the tile memory back if the mask is zero or the
// table entry is valid. The result sits in an output register, so the next
// item is taken while it waits; a second compute stalls at write-back until
// the earlier result is taken. Mapping table entries carry valid bits in
// flip-flops cleared by reset, so there is no clearing pass.
module tile_autotile_transition_unit
    import tat_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int CLASS_BITS = DEF_CLASS_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tat_in_if.sink               i_in,
    tat_out_if.source            o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CB    = $clog2(MAX_COLS);
    localparam int RB    = $clog2(MAX_ROWS);
    localparam int XW    = $clog2(MAX_COLS + 1);
    localparam int YW    = $clog2(MAX_ROWS + 1);
    localparam int XB    = (XW > 9) ? XW : 9;
    localparam int YB    = (YW > 9) ? YW : 9;

    // wrap tables for the 8-bit center coordinates
    function automatic logic [256*CB-1:0] col_wrap_tab();
        logic [256*CB-1:0] t;
        t = '0;
        for (int i = 0; i < 256; i++) t[i*CB +: CB] = CB'(i % MAX_COLS);
        return t;
    endfunction

    function automatic logic [256*RB-1:0] row_wrap_tab();
        logic [256*RB-1:0] t;
        t = '0;
        for (int i = 0; i < 256; i++) t[i*RB +: RB] = RB'(i % MAX_ROWS);
        return t;
    endfunction

    localparam logic [256*CB-1:0] COL_WRAP = col_wrap_tab();
    localparam logic [256*RB-1:0] ROW_WRAP = row_wrap_tab();

    typedef enum logic [2:0] {
        S_IDLE, S_WCLS, S_WTBL, S_RDC, S_NB, S_LAST, S_KEY, S_WR
    } t_state;

    // configuration registers
    logic [8:0] r_map_w, r_map_h;
    logic       r_mode;
    logic [7:0] r_src, r_tgt, r_clear;
    logic       w_cfg_wr;
    t_reg       w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_idx = t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= 9'd256;
            r_map_h <= 9'd256;
            r_mode  <= 1'b0;
            r_src   <= '0;
            r_tgt   <= '0;
            r_clear <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_MAP_WIDTH:    r_map_w <= pwdata[8:0];
                REG_MAP_HEIGHT:   r_map_h <= pwdata[8:0];
                REG_MATCH_MODE:   r_mode  <= pwdata[0];
                REG_SOURCE_CLASS: r_src   <= pwdata[7:0];
                REG_TARGET_CLASS: r_tgt   <= pwdata[7:0];
                REG_CLEAR_TILE:   r_clear <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_MAP_WIDTH:    prdata = DATA_BITS'(r_map_w);
            REG_MAP_HEIGHT:   prdata = DATA_BITS'(r_map_h);
            REG_MATCH_MODE:   prdata = DATA_BITS'(r_mode);
            REG_SOURCE_CLASS: prdata = DATA_BITS'(r_src);
            REG_TARGET_CLASS: prdata = DATA_BITS'(r_tgt);
            REG_CLEAR_TILE:   prdata = DATA_BITS'(r_clear);
            default:          prdata = '0;
        endcase
    end

    // sequencer state
    t_state                r_state;
    logic [7:0]            r_col, r_row;
    logic [AW-1:0]         r_caddr;
    logic [CLASS_BITS-1:0] r_cls;
    logic [7:0]            r_tidx, r_ttile;
    logic                  r_tvld;
    logic [2:0]            r_step;
    logic                  r_prev_inb;
    logic                  r_gate;
    logic [7:0]            r_mask;
    logic                  r_ent_vld;
    logic                  r_out_vld;
    logic [7:0]            r_out_mask, r_out_tile;
    logic                  r_out_chg;
    logic [255:0]          r_tbl_vld;

    // memories and their registered read data
    logic [CLASS_BITS-1:0] m_class [DEPTH];
    logic [7:0]            m_tile  [DEPTH];
    logic [7:0]            m_table [256];
    logic [CLASS_BITS-1:0] r_cls_rd;
    logic [7:0]            r_tile_rd, r_tbl_rd;

    logic [CLASS_BITS-1:0] w_src_c, w_tgt_c;
    logic [AW-1:0]         w_in_addr, w_nb_addr, w_cls_raddr;
    logic [XB-1:0]         w_cx, w_bx, w_nx;
    logic [YB-1:0]         w_cy, w_by, w_ny;
    logic                  w_inb_x, w_inb_y, w_inb;
    logic                  w_match, w_gate_now;
    logic [7:0]            w_key;
    logic                  w_out_xfer, w_wr_stall;
    logic                  w_tile_we;
    logic [7:0]            w_tile_wd;
    logic [7:0]            w_mask_fin;

    assign w_src_c = CLASS_BITS'(r_src);
    assign w_tgt_c = CLASS_BITS'(r_tgt);

    assign w_in_addr = AW'(ROW_WRAP[int'(i_in.row)*RB +: RB]) * AW'(MAX_COLS)
                     + AW'(COL_WRAP[int'(i_in.col)*CB +: CB]);

    // neighbor coordinates and bounds for the current step
    assign w_cx = XB'(r_col);
    assign w_cy = YB'(r_row);
    assign w_bx = (XB'(r_map_w) > XB'(MAX_COLS)) ? XB'(MAX_COLS) : XB'(r_map_w);
    assign w_by = (YB'(r_map_h) > YB'(MAX_ROWS)) ? YB'(MAX_ROWS) : YB'(r_map_h);

    always_comb begin
        unique case (nb_dx(r_step))
            D_NEG: begin
                w_nx    = w_cx - XB'(1);
                w_inb_x = (w_cx != '0) && (w_nx < w_bx);
            end
            D_ZERO: begin
                w_nx    = w_cx;
                w_inb_x = w_cx < w_bx;
            end
            default: begin
                w_nx    = w_cx + XB'(1);
                w_inb_x = w_nx < w_bx;
            end
        endcase
        unique case (nb_dy(r_step))
            D_NEG: begin
                w_ny    = w_cy - YB'(1);
                w_inb_y = (w_cy != '0) && (w_ny < w_by);
            end
            D_ZERO: begin
                w_ny    = w_cy;
                w_inb_y = w_cy < w_by;
            end
            default: begin
                w_ny    = w_cy + YB'(1);
                w_inb_y = w_ny < w_by;
            end
        endcase
    end

    assign w_inb     = w_inb_x & w_inb_y;
    assign w_nb_addr = AW'(w_ny[RB-1:0]) * AW'(MAX_COLS) + AW'(w_nx[CB-1:0]);
    // out-of-map neighbors read the center so the address stays in range
    assign w_cls_raddr = (r_state == S_NB && w_inb) ? w_nb_addr : r_caddr;

    assign w_match    = r_prev_inb && (r_cls_rd == w_tgt_c);
    assign w_gate_now = (r_mode == MODE_PAIR) ? (r_cls_rd == w_src_c) : (r_cls_rd != w_tgt_c);
    assign w_mask_fin = r_gate ? {w_match, r_mask[6:0]} : 8'd0;
    assign w_key      = (r_mask[3:0] != 4'd0) ? {4'd0, r_mask[3:0]} : r_mask;

    assign w_out_xfer = r_out_vld & o_out.ready;
    assign w_wr_stall = r_out_vld & ~o_out.ready;
    assign w_tile_we  = (r_state == S_WR) && !w_wr_stall && ((r_mask == 8'd0) || r_ent_vld);
    assign w_tile_wd  = (r_mask == 8'd0) ? r_clear : r_tbl_rd;

    always_ff @(posedge i_clk) begin
        if (r_state == S_WCLS) m_class[r_caddr] <= r_cls;
        r_cls_rd <= m_class[w_cls_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_tile_we) m_tile[r_caddr] <= w_tile_wd;
        if (r_state == S_RDC) r_tile_rd <= m_tile[r_caddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WTBL) m_table[r_tidx] <= r_ttile;
        if (r_state == S_KEY) r_tbl_rd <= m_table[w_key];
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_vld;
    assign o_out.neighbor_mask = r_out_mask;
    assign o_out.result_tile   = r_out_tile;
    assign o_out.tile_changed  = r_out_chg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_tbl_vld <= '0;
            r_step    <= '0;
        end else begin
            // a new result replaces the one leaving in the same cycle
            if (r_state == S_WR && !w_wr_stall) begin
                r_out_vld <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_col   <= i_in.col;
                        r_row   <= i_in.row;
                        r_caddr <= w_in_addr;
                        r_cls   <= CLASS_BITS'(i_in.cell_class);
                        r_tidx  <= i_in.table_index;
                        r_ttile <= i_in.table_tile;
                        r_tvld  <= i_in.table_valid;
                        unique case (t_kind'(i_in.kind))
                            KIND_WR_CLASS:   r_state <= S_WCLS;
                            KIND_LOAD_TABLE: r_state <= S_WTBL;
                            KIND_COMPUTE:    r_state <= S_RDC;
                            default:         r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WCLS: r_state <= S_IDLE;
                S_WTBL: begin
                    r_tbl_vld[r_tidx] <= r_tvld;
                    r_state           <= S_IDLE;
                end
                S_RDC: begin
                    r_step  <= '0;
                    r_mask  <= '0;
                    r_state <= S_NB;
                end
                S_NB: begin
                    // read data of the previous step lands this cycle
                    if (r_step == 3'd0) r_gate <= w_gate_now;
                    else r_mask[r_step - 3'd1] <= w_match;
                    r_prev_inb <= w_inb;
                    r_step     <= r_step + 3'd1;
                    if (r_step == 3'd7) r_state <= S_LAST;
                end
                S_LAST: begin
                    r_mask  <= w_mask_fin;
                    r_state <= S_KEY;
                end
                S_KEY: begin
                    r_ent_vld <= r_tbl_vld[w_key];
                    r_state   <= S_WR;
                end
                S_WR: begin
                    if (!w_wr_stall) begin
                        r_out_mask <= r_mask;
                        r_out_tile <= w_tile_we ? w_tile_wd : r_tile_rd;
                        r_out_chg  <= w_tile_we;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/tat_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// tat_checker
// Port-level checks on the autotile transition unit, bound to the top level.
// ============================================================================
module tat_checker
    import tat_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_kind,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_mask,
    input logic       i_out_chg
);

    logic w_in_xfer;
    assign w_in_xfer = i_in_valid & i_in_ready;

    // a pending result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    // a compute keeps the unit busy after its transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && (i_in_kind == KIND_COMPUTE) |=> !i_in_ready)
        else $error("input taken during compute");

    // no result appears right after an input transfer
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !$rose(i_out_valid))
        else $error("result too early");

    // a zero mask always writes the clear tile, so its result is marked changed
    a_zero_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_chg || (i_out_mask != 8'd0)))
        else $error("zero mask left tile unchanged");

endmodule

bind tile_autotile_transition_unit tat_checker u_tat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_mask  (o_out.neighbor_mask),
    .i_out_chg   (o_out.tile_changed)
);
